// File: src/vsgc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and single-precision helper functions of the shear gradient unit.
package vsgc_pkg;

   localparam int unsigned FP_WIDTH = 32;
   localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
   localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;

   localparam int unsigned MUL_LAT   = 3;
   localparam int unsigned ADD_LAT   = 4;
   localparam int unsigned DIV_QBITS = 27;
   localparam int unsigned DIV_LAT   = DIV_QBITS + 3;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VISC_ALPHA  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELAX_COUNT = 2'd1;

   localparam logic [31:0] VISC_ALPHA_RESET  = 32'h0000_0000;
   localparam logic [3:0]  RELAX_COUNT_RESET = 4'd1;

   typedef struct packed {
      logic [31:0] shear_velocity;
      logic [31:0] density;
      logic [31:0] tau_shear;
   } vsgc_req_type;

   typedef struct packed {
      logic [31:0] mu_weight_one;
      logic [31:0] mu_weight_four;
      logic [31:0] tau_weight_one;
      logic [31:0] tau_weight_four;
   } vsgc_rsp_type;

   typedef struct packed {
      logic              sign;
      logic signed [11:0] exp;
      logic [23:0]       sig;
      logic              nan;
      logic              inf;
      logic              zero;
   } fp_norm_type;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] cnt;
      cnt = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) begin
            cnt = 5'(23 - i);
         end
      end
      return cnt;
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] cnt;
      cnt = 5'd28;
      for (int i = 0; i < 28; i++) begin
         if (v[i]) begin
            cnt = 5'(27 - i);
         end
      end
      return cnt;
   endfunction

   function automatic fp_norm_type fp_normalize(input logic [31:0] x);
      logic [23:0] sig;
      logic [4:0]  lz;
      logic [11:0] e_eff;
      fp_norm_type r;
      sig     = {(x[30:23] != 8'd0), x[22:0]};
      lz      = lzc24(sig);
      e_eff   = (x[30:23] == 8'd0) ? 12'd1 : {4'd0, x[30:23]};
      r.sign  = x[31];
      r.exp   = $signed(e_eff) - $signed({7'd0, lz});
      r.sig   = sig << lz;
      r.nan   = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      r.inf   = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      r.zero  = (x[30:0] == 31'd0);
      return r;
   endfunction

   function automatic logic [26:0] shr_sticky(input logic [26:0] v, input logic [4:0] amt);
      logic [26:0] mask;
      logic [26:0] shifted;
      mask    = (27'd1 << amt) - 27'd1;
      shifted = v >> amt;
      return {shifted[26:1], shifted[0] | (|(v & mask))};
   endfunction

   // The significand carries its leading one at bit 26, then guard, round and sticky.
   function automatic logic [31:0] fp_round_pack(input logic sign,
                                                 input logic signed [11:0] e,
                                                 input logic [26:0] m);
      logic signed [11:0] amt_s;
      logic [4:0]         amt;
      logic [26:0]        ms;
      logic signed [11:0] es;
      logic               inc;
      logic [24:0]        mant;
      logic [11:0]        em1;
      logic [34:0]        pk;
      ms    = m;
      es    = e;
      amt_s = 12'sd1 - e;
      amt   = (amt_s > 12'sd31) ? 5'd31 : amt_s[4:0];
      if (e < 12'sd1) begin
         ms = shr_sticky(m, amt);
         es = 12'sd1;
      end
      inc  = ms[2] & (ms[1] | ms[0] | ms[3]);
      mant = {1'b0, ms[26:3]} + {24'd0, inc};
      em1  = es - 12'sd1;
      pk   = {em1, 23'd0} + {10'd0, mant};
      if (pk[34:23] >= 12'd255) begin
         return {sign, 8'hFF, 23'd0};
      end
      return {sign, pk[30:0]};
   endfunction

   function automatic logic [31:0] int_to_fp4(input logic [3:0] v);
      logic [1:0] msb;
      logic [3:0] norm;
      msb = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (v[i]) begin
            msb = 2'(i);
         end
      end
      norm = v << (2'd3 - msb);
      if (v == 4'd0) begin
         return 32'd0;
      end
      return {1'b0, 8'd127 + {6'd0, msb}, norm[2:0], 20'd0};
   endfunction

endpackage

// File: src/visco_shear_grad_coeff_unit.sv
`timescale 1ns / 1ps
// Throughput: one grid point per cycle; the whole float pipeline advances as one.
// The pipeline freezes only while a finished response waits under rsp_stall.
// Depth is set by four chained multipliers and two chained 30-stage dividers.
// Synchronous reset clears the valid bits and loads visc_alpha = 0, relax_count = 1.
module visco_shear_grad_coeff_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  vsgc_pkg::vsgc_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output vsgc_pkg::vsgc_rsp_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vsgc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                           csr_wdata
);

   localparam int unsigned ML = vsgc_pkg::MUL_LAT;
   localparam int unsigned AL = vsgc_pkg::ADD_LAT;
   localparam int unsigned DL = vsgc_pkg::DIV_LAT;

   localparam int unsigned T_VS2 = ML;
   localparam int unsigned T_LA  = AL;
   localparam int unsigned T_MU  = 2 * ML;
   localparam int unsigned T_N   = ML + AL;
   localparam int unsigned T_M2  = 3 * ML;
   localparam int unsigned T_MT  = 3 * ML;
   localparam int unsigned T_DD  = T_N + ML;
   localparam int unsigned T_RMU = T_MU + DL;
   localparam int unsigned T_RM2 = T_M2 + DL;
   localparam int unsigned T_MTT = T_MT + ML;
   localparam int unsigned T_T4  = T_MTT + DL;
   localparam int unsigned T_P   = T_RMU + ML;
   localparam int unsigned T_RN  = T_RM2 + ML;
   localparam int unsigned T_T1  = T_P + DL;
   localparam int unsigned T_W   = T_RN + DL;
   localparam int unsigned PIPE_DEPTH = T_W;

   logic        advance;
   logic [31:0] visc_alpha_ff, visc_alpha_in;
   logic [3:0]  relax_count_ff, relax_count_in;
   logic [PIPE_DEPTH-1:0]  valid_pipe_ff, valid_pipe_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   vsgc_pkg::vsgc_rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] l_float, neg_alpha;
   logic [31:0] vs2, at, lt, la, rho_d, mu, n, dsum, tau_d6, m2, rmu, mt, dd;
   logic [31:0] rm2, tau_d9, mtt, t4, la_d, p, n_d, rn, dd_d, t1, d_d, w1, tau_dl, w4;
   logic [31:0] t4_d, t1_d;
   logic        nan_canonical;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;
   assign l_float   = vsgc_pkg::int_to_fp4(relax_count_ff);
   assign neg_alpha = {~visc_alpha_ff[31], visc_alpha_ff[30:0]};

   vsgc_fmul u_vs2 (.clock, .enable(advance), .op_a(req_data.shear_velocity),
                    .op_b(req_data.shear_velocity), .result(vs2));
   vsgc_fmul u_at  (.clock, .enable(advance), .op_a(visc_alpha_ff),
                    .op_b(req_data.tau_shear), .result(at));
   vsgc_fmul u_lt  (.clock, .enable(advance), .op_a(l_float),
                    .op_b(req_data.tau_shear), .result(lt));
   vsgc_fadd u_la  (.clock, .enable(advance), .op_a(l_float), .op_b(neg_alpha), .result(la));

   vsgc_delay #(.DEPTH(T_VS2)) u_rho_dly (.clock, .enable(advance),
                                          .din(req_data.density), .dout(rho_d));
   vsgc_fmul u_mu (.clock, .enable(advance), .op_a(vs2), .op_b(rho_d), .result(mu));
   vsgc_fadd u_n  (.clock, .enable(advance), .op_a(vsgc_pkg::FP_ONE), .op_b(at), .result(n));
   vsgc_fadd u_d  (.clock, .enable(advance), .op_a(vsgc_pkg::FP_ONE), .op_b(lt), .result(dsum));

   vsgc_delay #(.DEPTH(T_MU)) u_tau6_dly (.clock, .enable(advance),
                                          .din(req_data.tau_shear), .dout(tau_d6));
   vsgc_fmul u_m2  (.clock, .enable(advance), .op_a(mu), .op_b(mu), .result(m2));
   vsgc_fdiv u_rmu (.clock, .enable(advance), .op_a(vsgc_pkg::FP_ONE), .op_b(mu), .result(rmu));
   vsgc_fmul u_mt  (.clock, .enable(advance), .op_a(mu), .op_b(tau_d6), .result(mt));
   vsgc_fmul u_dd  (.clock, .enable(advance), .op_a(dsum), .op_b(dsum), .result(dd));

   vsgc_fdiv u_rm2 (.clock, .enable(advance), .op_a(vsgc_pkg::FP_ONE), .op_b(m2), .result(rm2));
   vsgc_delay #(.DEPTH(T_MT)) u_tau9_dly (.clock, .enable(advance),
                                          .din(req_data.tau_shear), .dout(tau_d9));
   vsgc_fmul u_mtt (.clock, .enable(advance), .op_a(mt), .op_b(tau_d9), .result(mtt));
   vsgc_fdiv u_t4  (.clock, .enable(advance), .op_a(vsgc_pkg::FP_ONE), .op_b(mtt), .result(t4));

   vsgc_delay #(.DEPTH(T_RMU - T_LA)) u_la_dly (.clock, .enable(advance), .din(la), .dout(la_d));
   vsgc_fmul u_p (.clock, .enable(advance), .op_a(rmu), .op_b(la_d), .result(p));
   vsgc_delay #(.DEPTH(T_RM2 - T_N)) u_n_dly (.clock, .enable(advance), .din(n), .dout(n_d));
   vsgc_fmul u_rn (.clock, .enable(advance), .op_a(rm2), .op_b(n_d), .result(rn));

   vsgc_delay #(.DEPTH(T_P - T_DD)) u_dd_dly (.clock, .enable(advance), .din(dd), .dout(dd_d));
   vsgc_fdiv u_t1 (.clock, .enable(advance), .op_a(p), .op_b(dd_d), .result(t1));
   vsgc_delay #(.DEPTH(T_RN - T_N)) u_d_dly (.clock, .enable(advance), .din(dsum), .dout(d_d));
   vsgc_fdiv u_w1 (.clock, .enable(advance), .op_a(rn), .op_b(d_d), .result(w1));
   vsgc_delay #(.DEPTH(T_RN)) u_tau_dly (.clock, .enable(advance),
                                         .din(req_data.tau_shear), .dout(tau_dl));
   vsgc_fdiv u_w4 (.clock, .enable(advance), .op_a(rn), .op_b(tau_dl), .result(w4));

   vsgc_delay #(.DEPTH(T_W - T_T4)) u_t4_dly (.clock, .enable(advance), .din(t4), .dout(t4_d));
   vsgc_delay #(.DEPTH(T_W - T_T1)) u_t1_dly (.clock, .enable(advance), .din(t1), .dout(t1_d));

   always_comb begin
      visc_alpha_in  = visc_alpha_ff;
      relax_count_in = relax_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vsgc_pkg::CSR_VISC_ALPHA: begin
               visc_alpha_in = csr_wdata;
            end
            vsgc_pkg::CSR_RELAX_COUNT: begin
               relax_count_in = csr_wdata[3:0];
            end
            default: begin
            end
         endcase
      end

      valid_pipe_in = valid_pipe_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (advance) begin
         valid_pipe_in               = {valid_pipe_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_in                = valid_pipe_ff[PIPE_DEPTH-1];
         rsp_data_in.mu_weight_one   = w1;
         rsp_data_in.mu_weight_four  = w4;
         rsp_data_in.tau_weight_one  = t1_d;
         rsp_data_in.tau_weight_four = t4_d;
      end

      nan_canonical = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if ((rsp_data_ff[32*i+30 -: 8] == 8'hFF) && (rsp_data_ff[32*i+22 -: 23] != 23'd0)
             && (rsp_data_ff[32*i+31 -: 32] != vsgc_pkg::FP_QNAN)) begin
            nan_canonical = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visc_alpha_ff  <= vsgc_pkg::VISC_ALPHA_RESET;
         relax_count_ff <= vsgc_pkg::RELAX_COUNT_RESET;
         valid_pipe_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         visc_alpha_ff  <= visc_alpha_in;
         relax_count_ff <= relax_count_in;
         valid_pipe_ff  <= valid_pipe_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(valid_pipe_ff))
      else $error("Pipeline valid bits moved while the response beat was held.");

   a_tail_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (valid_pipe_ff[PIPE_DEPTH-1] && !req_stall) |=> rsp_valid_ff)
      else $error("A finished item did not reach the response register.");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!valid_pipe_ff[PIPE_DEPTH-1] && !req_stall) |=> !rsp_valid_ff)
      else $error("A response beat appeared without an item in the last stage.");

   a_nan_canon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> nan_canonical)
      else $error("A NaN result is not the canonical quiet NaN.");

endmodule

// File: src/vsgc_delay.sv
`timescale 1ns / 1ps
// Enabled shift line that holds operands back to meet their partners in the pipeline.
module vsgc_delay #(
   parameter int unsigned WIDTH = vsgc_pkg::FP_WIDTH,
   parameter int unsigned DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// File: src/vsgc_fmul.sv
`timescale 1ns / 1ps
// Three-stage single-precision multiplier: normalize, multiply, round.
module vsgc_fmul (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] result
);

   vsgc_pkg::fp_norm_type a_ff, b_ff, a_in, b_in;
   logic [47:0]        prod_ff, prod_in;
   logic signed [11:0] exp_ff, exp_in;
   logic               sign_ff, sign_in;
   logic               nan_ff, nan_in;
   logic               inf_ff, inf_in;
   logic               zero_ff, zero_in;
   logic [31:0]        result_ff, result_in;
   logic [26:0]        mant;
   logic signed [11:0] exp_adj;

   always_comb begin
      a_in    = vsgc_pkg::fp_normalize(op_a);
      b_in    = vsgc_pkg::fp_normalize(op_b);
      prod_in = {24'd0, a_ff.sig} * {24'd0, b_ff.sig};
      exp_in  = $signed(a_ff.exp) + $signed(b_ff.exp);
      sign_in = a_ff.sign ^ b_ff.sign;
      nan_in  = a_ff.nan | b_ff.nan | (a_ff.inf & b_ff.zero) | (a_ff.zero & b_ff.inf);
      inf_in  = a_ff.inf | b_ff.inf;
      zero_in = a_ff.zero | b_ff.zero;

      if (prod_ff[47]) begin
         mant    = {prod_ff[47:22], prod_ff[21] | (|prod_ff[20:0])};
         exp_adj = exp_ff - 12'sd126;
      end else begin
         mant    = {prod_ff[46:21], prod_ff[20] | (|prod_ff[19:0])};
         exp_adj = exp_ff - 12'sd127;
      end

      priority if (nan_ff) begin
         result_in = vsgc_pkg::FP_QNAN;
      end else if (inf_ff) begin
         result_in = {sign_ff, 8'hFF, 23'd0};
      end else if (zero_ff) begin
         result_in = {sign_ff, 31'd0};
      end else begin
         result_in = vsgc_pkg::fp_round_pack(sign_ff, exp_adj, mant);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         prod_ff   <= prod_in;
         exp_ff    <= exp_in;
         sign_ff   <= sign_in;
         nan_ff    <= nan_in;
         inf_ff    <= inf_in;
         zero_ff   <= zero_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: src/vsgc_fadd.sv
`timescale 1ns / 1ps
// Four-stage single-precision adder: align, add, normalize, round.
module vsgc_fadd (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] result
);

   typedef struct packed {
      logic        sign;
      logic        zsign;
      logic        sub;
      logic [7:0]  exp;
      logic [26:0] big;
      logic [26:0] small_sig;
      logic        nan;
      logic        inf;
   } align_type;

   typedef struct packed {
      logic        sign;
      logic        zsign;
      logic [7:0]  exp;
      logic [27:0] sum;
      logic        nan;
      logic        inf;
   } sum_type;

   typedef struct packed {
      logic              sign;
      logic              zsign;
      logic signed [11:0] exp;
      logic [26:0]       mant;
      logic              nan;
      logic              inf;
      logic              zero;
   } norm_type;

   align_type   al_ff, al_in;
   sum_type     sm_ff, sm_in;
   norm_type    nm_ff, nm_in;
   logic [31:0] result_ff, result_in;

   logic        swap;
   logic [31:0] big, lesser;
   logic [7:0]  big_e, lesser_e, diff;
   logic [4:0]  amt;
   logic        a_nan, b_nan, a_inf, b_inf;
   logic [4:0]  lz;
   logic [4:0]  lsh;
   logic [27:0] shifted;

   always_comb begin
      a_nan    = (op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0);
      b_nan    = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
      a_inf    = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
      b_inf    = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
      swap     = op_b[30:0] > op_a[30:0];
      big      = swap ? op_b : op_a;
      lesser   = swap ? op_a : op_b;
      big_e    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      lesser_e = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
      diff     = big_e - lesser_e;
      amt      = (diff > 8'd31) ? 5'd31 : diff[4:0];

      al_in.sign      = big[31];
      al_in.zsign     = op_a[31] & op_b[31];
      al_in.sub       = big[31] ^ lesser[31];
      al_in.exp       = big_e;
      al_in.big       = {(big[30:23] != 8'd0), big[22:0], 3'b000};
      al_in.small_sig = vsgc_pkg::shr_sticky({(lesser[30:23] != 8'd0), lesser[22:0], 3'b000},
                                             amt);
      al_in.nan       = a_nan | b_nan | (a_inf & b_inf & (op_a[31] != op_b[31]));
      al_in.inf       = a_inf | b_inf;

      sm_in.sign  = al_ff.sign;
      sm_in.zsign = al_ff.zsign;
      sm_in.exp   = al_ff.exp;
      sm_in.sum   = al_ff.sub ? ({1'b0, al_ff.big} - {1'b0, al_ff.small_sig})
                              : ({1'b0, al_ff.big} + {1'b0, al_ff.small_sig});
      sm_in.nan   = al_ff.nan;
      sm_in.inf   = al_ff.inf;

      lz      = vsgc_pkg::lzc28(sm_ff.sum);
      lsh     = lz - 5'd1;
      shifted = sm_ff.sum << lsh;
      nm_in.sign  = sm_ff.sign;
      nm_in.zsign = sm_ff.zsign;
      nm_in.nan   = sm_ff.nan;
      nm_in.inf   = sm_ff.inf;
      nm_in.zero  = (sm_ff.sum == 28'd0);
      if (sm_ff.sum[27]) begin
         nm_in.mant = {sm_ff.sum[27:2], sm_ff.sum[1] | sm_ff.sum[0]};
         nm_in.exp  = $signed({4'd0, sm_ff.exp}) + 12'sd1;
      end else begin
         nm_in.mant = shifted[26:0];
         nm_in.exp  = $signed({4'd0, sm_ff.exp}) - $signed({7'd0, lsh});
      end

      priority if (nm_ff.nan) begin
         result_in = vsgc_pkg::FP_QNAN;
      end else if (nm_ff.inf) begin
         result_in = {nm_ff.sign, 8'hFF, 23'd0};
      end else if (nm_ff.zero) begin
         result_in = {nm_ff.zsign, 31'd0};
      end else begin
         result_in = vsgc_pkg::fp_round_pack(nm_ff.sign, nm_ff.exp, nm_ff.mant);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         al_ff     <= al_in;
         sm_ff     <= sm_in;
         nm_ff     <= nm_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: src/vsgc_fdiv.sv
`timescale 1ns / 1ps
// Single-precision divider pipelined one quotient bit per stage, with normalize and round stages.
module vsgc_fdiv (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] result
);

   localparam int unsigned QBITS = vsgc_pkg::DIV_QBITS;

   typedef struct packed {
      logic              sign;
      logic signed [11:0] exp;
      logic [24:0]       rem;
      logic [23:0]       den;
      logic [26:0]       quo;
      logic              nan;
      logic              inf;
      logic              zero;
   } stage_type;

   vsgc_pkg::fp_norm_type a_ff, b_ff, a_in, b_in;
   stage_type   stage_ff [0:QBITS];
   stage_type   stage_in [0:QBITS];
   logic [31:0] result_ff, result_in;
   logic [26:0] mant;
   logic [24:0] diff [1:QBITS];
   logic        ge   [1:QBITS];

   always_comb begin
      a_in = vsgc_pkg::fp_normalize(op_a);
      b_in = vsgc_pkg::fp_normalize(op_b);

      stage_in[0].sign = a_ff.sign ^ b_ff.sign;
      stage_in[0].den  = b_ff.sig;
      stage_in[0].quo  = 27'd0;
      stage_in[0].nan  = a_ff.nan | b_ff.nan | (a_ff.zero & b_ff.zero) | (a_ff.inf & b_ff.inf);
      stage_in[0].inf  = a_ff.inf | b_ff.zero;
      stage_in[0].zero = a_ff.zero | b_ff.inf;
      if (a_ff.sig >= b_ff.sig) begin
         stage_in[0].rem = {1'b0, a_ff.sig};
         stage_in[0].exp = $signed(a_ff.exp) - $signed(b_ff.exp) + 12'sd127;
      end else begin
         stage_in[0].rem = {a_ff.sig, 1'b0};
         stage_in[0].exp = $signed(a_ff.exp) - $signed(b_ff.exp) + 12'sd126;
      end

      for (int k = 1; k <= QBITS; k++) begin
         ge[k]           = stage_ff[k-1].rem >= {1'b0, stage_ff[k-1].den};
         diff[k]         = ge[k] ? (stage_ff[k-1].rem - {1'b0, stage_ff[k-1].den})
                                 : stage_ff[k-1].rem;
         stage_in[k]     = stage_ff[k-1];
         stage_in[k].rem = {diff[k][23:0], 1'b0};
         stage_in[k].quo = {stage_ff[k-1].quo[25:0], ge[k]};
      end

      mant = {stage_ff[QBITS].quo[26:1],
              stage_ff[QBITS].quo[0] | (stage_ff[QBITS].rem != 25'd0)};

      priority if (stage_ff[QBITS].nan) begin
         result_in = vsgc_pkg::FP_QNAN;
      end else if (stage_ff[QBITS].inf) begin
         result_in = {stage_ff[QBITS].sign, 8'hFF, 23'd0};
      end else if (stage_ff[QBITS].zero) begin
         result_in = {stage_ff[QBITS].sign, 31'd0};
      end else begin
         result_in = vsgc_pkg::fp_round_pack(stage_ff[QBITS].sign, stage_ff[QBITS].exp, mant);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff <= a_in;
         b_ff <= b_in;
         for (int k = 0; k <= QBITS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the shear gradient unit against an IEEE-single predictor.
module tb;

   localparam logic [vsgc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 100;
   localparam int IDLE_LIMIT   = 3000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   vsgc_pkg::vsgc_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   vsgc_pkg::vsgc_rsp_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [vsgc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]            csr_wdata = '0;

   logic [31:0]            alpha_bits;
   logic [3:0]             relax_num;
   vsgc_pkg::vsgc_rsp_type weights_due[$];
   int                     error_count = 0;
   int                     idle_cycles = 0;
   int                     burst_left = 0;
   int                     stall_mode = 0;
   int                     stall_span = 0;

   visco_shear_grad_coeff_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic real fp_to_real(input logic [31:0] x);
      logic [63:0] d;
      logic [22:0] m;
      int          e;
      m = x[22:0];
      e = x[30:23];
      if (e == 255) begin
         d = {x[31], 11'h7FF, m, 29'd0};
      end else if (e == 0) begin
         if (m == 0) begin
            d = {x[31], 63'd0};
         end else begin
            e = 1;
            while (!m[22]) begin
               m = m << 1;
               e--;
            end
            m = m << 1;
            d = {x[31], 11'(e - 128 + 1023), m, 29'd0};
         end
      end else begin
         d = {x[31], 11'(e - 127 + 1023), m, 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   // Products of two singles are exact in double, and sums and quotients
   // rounded twice still land on the correctly rounded single.
   function automatic logic [31:0] real_to_fp(input real r);
      logic [63:0] b;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          e;
      int          sh;
      b = $realtobits(r);
      if (b[62:52] == 11'h7FF) begin
         return (b[51:0] != 0) ? vsgc_pkg::FP_QNAN : {b[63], 8'hFF, 23'd0};
      end
      if (b[62:52] == 11'd0) begin
         return {b[63], 31'd0};
      end
      e = int'(b[62:52]) - 1023 + 127;
      m = {11'd0, 1'b1, b[51:0]};
      sh = (e >= 1) ? 29 : 29 + (1 - e);
      if (sh > 55) begin
         sh = 55;
      end
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) begin
         q = q + 64'd1;
      end
      if (e < 1) begin
         return {b[63], q[30:0]};
      end
      if (q == 64'd1 << 24) begin
         q = q >> 1;
         e++;
      end
      if (e >= 255) begin
         return {b[63], 8'hFF, 23'd0};
      end
      return {b[63], 8'(e), q[22:0]};
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      return real_to_fp(fp_to_real(a) * fp_to_real(b));
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      return real_to_fp(fp_to_real(a) + fp_to_real(b));
   endfunction

   function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
      return real_to_fp(fp_to_real(a) - fp_to_real(b));
   endfunction

   function automatic logic [31:0] fdiv(input logic [31:0] a, input logic [31:0] b);
      return real_to_fp(fp_to_real(a) / fp_to_real(b));
   endfunction

   function automatic vsgc_pkg::vsgc_rsp_type shear_weights(input vsgc_pkg::vsgc_req_type p);
      logic [31:0] lf, mu, m2, n, d, rn, rmu, pl, dd, mtt;
      vsgc_pkg::vsgc_rsp_type w;
      lf  = real_to_fp(real'(relax_num));
      mu  = fmul(fmul(p.shear_velocity, p.shear_velocity), p.density);
      m2  = fmul(mu, mu);
      n   = fadd(vsgc_pkg::FP_ONE, fmul(alpha_bits, p.tau_shear));
      d   = fadd(vsgc_pkg::FP_ONE, fmul(lf, p.tau_shear));
      rn  = fmul(fdiv(vsgc_pkg::FP_ONE, m2), n);
      rmu = fdiv(vsgc_pkg::FP_ONE, mu);
      pl  = fmul(rmu, fsub(lf, alpha_bits));
      dd  = fmul(d, d);
      mtt = fmul(fmul(mu, p.tau_shear), p.tau_shear);
      w.mu_weight_one   = fdiv(rn, d);
      w.mu_weight_four  = fdiv(rn, p.tau_shear);
      w.tau_weight_one  = fdiv(pl, dd);
      w.tau_weight_four = fdiv(vsgc_pkg::FP_ONE, mtt);
      return w;
   endfunction

   function automatic logic [31:0] pick_float();
      logic [31:0] specials[10];
      specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0001, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
                   32'h7F7F_FFFF, vsgc_pkg::FP_ONE};
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: return specials[$urandom_range(0, 9)];
         default: return {($urandom_range(0, 9) == 0), 8'($urandom_range(107, 147)),
                          23'($urandom)};
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb: %s mismatch at %0t: got %h expected %h", what, $time, got, want);
      error_count++;
   endtask

   task automatic drop_request();
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic send_point(input vsgc_pkg::vsgc_req_type p);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      weights_due.push_back(shear_weights(p));
      burst_left--;
   endtask

   task automatic wait_drained();
      drop_request();
      @(posedge clock);
      while (weights_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] alpha, input logic [3:0] relax);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= vsgc_pkg::CSR_VISC_ALPHA;
      csr_wdata <= alpha;
      do @(posedge clock); while (!csr_ready);
      alpha_bits = alpha;
      csr_index <= vsgc_pkg::CSR_RELAX_COUNT;
      csr_wdata <= {$urandom_range(0, 1) ? 28'hFFFF_FFF : 28'd0, relax};
      do @(posedge clock); while (!csr_ready);
      relax_num = relax;
      csr_index <= CSR_UNUSED;
      csr_wdata <= $urandom;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic test_special_points();
      logic [31:0] vals[8];
      vsgc_pkg::vsgc_req_type p;
      vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
               32'hFFFF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF, vsgc_pkg::FP_ONE};
      for (int i = 0; i < 8; i++) begin
         p.shear_velocity = vals[i];
         p.density = vals[(i + 3) % 8];
         p.tau_shear = vals[(i + 5) % 8];
         send_point(p);
         p = {vsgc_pkg::FP_ONE, vsgc_pkg::FP_ONE, vals[i]};
         send_point(p);
      end
      send_point({32'h4000_0000, 32'h4040_0000, 32'h3F00_0000});
      send_point({32'h1E00_0000, 32'h1E00_0000, 32'h3F80_0000});
   endtask

   task automatic test_random_points(input int count);
      vsgc_pkg::vsgc_req_type p;
      for (int i = 0; i < count; i++) begin
         p.shear_velocity = pick_float();
         p.density = pick_float();
         p.tau_shear = pick_float();
         send_point(p);
      end
   endtask

   task automatic test_config_sweep();
      logic [31:0] alphas[6];
      logic [3:0]  relaxes[6];
      alphas = '{32'h0000_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3F00_0000,
                 32'hFF80_0000, 32'h0000_0001};
      relaxes = '{4'd15, 4'd0, 4'd3, 4'd1, 4'd15, 4'd7};
      for (int k = 0; k < 6; k++) begin
         write_config(alphas[k], relaxes[k]);
         test_random_points(150);
      end
      for (int k = 0; k < 4; k++) begin
         write_config(pick_float(), 4'($urandom));
         test_random_points(150);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(10, 200);
         end
         stall_span--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= (stall_span % 5 < 2);
            default: rsp_stall <= ($urandom_range(0, 5) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      vsgc_pkg::vsgc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (weights_due.size() == 0) begin
            $display("tb: unexpected response beat at %0t", $time);
            error_count++;
         end else begin
            want = weights_due.pop_front();
            if (rsp_data.mu_weight_one !== want.mu_weight_one)
               report_mismatch("mu_weight_one", rsp_data.mu_weight_one, want.mu_weight_one);
            if (rsp_data.mu_weight_four !== want.mu_weight_four)
               report_mismatch("mu_weight_four", rsp_data.mu_weight_four, want.mu_weight_four);
            if (rsp_data.tau_weight_one !== want.tau_weight_one)
               report_mismatch("tau_weight_one", rsp_data.tau_weight_one, want.tau_weight_one);
            if (rsp_data.tau_weight_four !== want.tau_weight_four)
               report_mismatch("tau_weight_four", rsp_data.tau_weight_four,
                               want.tau_weight_four);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      alpha_bits = vsgc_pkg::VISC_ALPHA_RESET;
      relax_num = vsgc_pkg::RELAX_COUNT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_points();
      test_random_points(100);
      test_config_sweep();
      write_config(32'h7F7F_FFFF, 4'd15);
      test_special_points();
      wait_drained();
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
